FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// All of them sample on the rising edge of i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_IMP(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`define ASSERT_NXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/i2c_ram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types, codes and segment lookup functions of the I2C master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2c_ram_pkg;

    localparam int PHASE_W = 16;

    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // One state for each bus segment of the write and read programs.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DEV,
        ST_ACK_DEV,
        ST_REG,
        ST_ACK_REG,
        ST_DATA,
        ST_ACK_DATA,
        ST_RSTART,
        ST_DEVR,
        ST_ACK_DEVR,
        ST_RDBYTE,
        ST_STOP
    } t_bus_state;

    typedef enum logic [2:0] {
        K_IDLE,
        K_START,
        K_WB,
        K_ACK,
        K_RB,
        K_STOP
    } t_seg_kind;

    typedef struct packed {
        logic step;
        logic clear;
    } t_tmr_ctl;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rd_data;
        logic       nack;
    } t_result;

    function automatic t_seg_kind seg_kind(input t_bus_state s);
        t_seg_kind k;
        case (s)
            ST_START, ST_RSTART:                k = K_START;
            ST_DEV, ST_REG, ST_DATA, ST_DEVR:   k = K_WB;
            ST_ACK_DEV, ST_ACK_REG,
            ST_ACK_DATA, ST_ACK_DEVR:           k = K_ACK;
            ST_RDBYTE:                          k = K_RB;
            ST_STOP:                            k = K_STOP;
            default:                            k = K_IDLE;
        endcase
        return k;
    endfunction

    // Index of the last bus step within a segment of the given kind.
    function automatic logic [1:0] sub_last(input t_seg_kind k);
        logic [1:0] n;
        case (k)
            K_START: n = 2'd1;
            K_WB:    n = 2'd2;
            K_ACK:   n = 2'd3;
            K_RB:    n = 2'd2;
            K_STOP:  n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/i2c_register_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C register access master core
// Single-byte register write and read master on open-drain SCL and SDA.
// ----------------------------------------------------------------------------
// Each input transaction is one bus timer tick carrying a request and the
// sampled SDA level. Each one yields exactly one output transaction with the
// line drive and status for that tick. One tick is taken every cycle while
// the result side is not stalled. A tick goes from the input register through
// the sequencer logic into the result register, from which its result is valid.
// A stalled result holds the tick waiting in the input register. With both
// registers full, the input stalls until the result is taken. On the bus, a
// write runs 89 steps and a read runs 115 steps after the accepting tick, and
// each step lasts phase_ticks ticks. Write phase_ticks only while no ticks
// are in flight.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master_core #(
    parameter int DIVIDER_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [1:0]  i_req_type,
    input  wire [7:0]  i_dev_addr,
    input  wire [7:0]  i_reg_addr,
    input  wire [7:0]  i_wr_data,
    input  wire        i_sda_in,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rd_data,
    output logic       o_nack_seen,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [15:0] i_cfg_data
);

    logic                               r_in_vld;
    logic [1:0]                         r_req_type;
    logic [7:0]                         r_dev_addr;
    logic [7:0]                         r_reg_addr;
    logic [7:0]                         r_wr_data;
    logic                               r_sda_in;
    logic                               r_out_vld;
    i2c_ram_pkg::t_result               r_out;
    logic [i2c_ram_pkg::PHASE_W-1:0]    r_phase_ticks;

    logic                               in_accept;
    logic                               advance;
    logic                               phase_end;
    i2c_ram_pkg::t_tmr_ctl              tmr_ctl;
    i2c_ram_pkg::t_result               result;

    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    i2c_ram_timer #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_phase_ticks),
        .i_ctl       (tmr_ctl),
        .o_phase_end (phase_end)
    );

    i2c_ram_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_req_type  (r_req_type),
        .i_dev_addr  (r_dev_addr),
        .i_reg_addr  (r_reg_addr),
        .i_wr_data   (r_wr_data),
        .i_sda_in    (r_sda_in),
        .i_phase_end (phase_end),
        .o_tmr_ctl   (tmr_ctl),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2c_ram_pkg::PHASE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type <= i_req_type;
            r_dev_addr <= i_dev_addr;
            r_reg_addr <= i_reg_addr;
            r_wr_data  <= i_wr_data;
            r_sda_in   <= i_sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_scl_out   = r_out.scl;
    assign o_sda_out   = r_out.sda;
    assign o_busy_res  = r_out.busy;
    assign o_done_res  = r_out.done;
    assign o_rd_data   = r_out.rd_data;
    assign o_nack_seen = r_out.nack;

endmodule

`default_nettype wire

FILE: rtl/i2c_ram_timer.sv
// ----------------------------------------------------------------------------
// I2C master step timer
// Counts ticks within one bus step and flags the last tick of the step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_ram_timer #(
    parameter int DIVIDER_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [i2c_ram_pkg::PHASE_W-1:0]      i_period,
    input  i2c_ram_pkg::t_tmr_ctl               i_ctl,
    output logic                                o_phase_end
);

    localparam int PW = (DIVIDER_WIDTH < i2c_ram_pkg::PHASE_W) ?
                        DIVIDER_WIDTH : i2c_ram_pkg::PHASE_W;
    localparam int CW = DIVIDER_WIDTH + 1;

    logic [DIVIDER_WIDTH-1:0] r_tick;
    logic [DIVIDER_WIDTH-1:0] n_tick;
    logic [PW-1:0]            masked;
    logic [PW-1:0]            period;
    logic [CW-1:0]            tick_inc;

    // A period of zero behaves as a period of one.
    assign masked      = i_period[PW-1:0];
    assign period      = (masked == '0) ? PW'(1) : masked;
    assign tick_inc    = {1'b0, r_tick} + CW'(1);
    assign o_phase_end = (tick_inc >= CW'(period));

    always_comb begin
        n_tick = r_tick;
        if (i_ctl.clear) begin
            n_tick = '0;
        end else if (i_ctl.step) begin
            n_tick = o_phase_end ? '0 : tick_inc[DIVIDER_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else begin
            r_tick <= n_tick;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2c_ram_seq.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Walks the write or read segment program, drives SCL and SDA, shifts the
// bytes out and in, and keeps the sticky nack flag and the read byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_ram_seq (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  wire [1:0]               i_req_type,
    input  wire [7:0]               i_dev_addr,
    input  wire [7:0]               i_reg_addr,
    input  wire [7:0]               i_wr_data,
    input  wire                     i_sda_in,
    input  wire                     i_phase_end,
    output i2c_ram_pkg::t_tmr_ctl   o_tmr_ctl,
    output i2c_ram_pkg::t_result    o_result
);

    i2c_ram_pkg::t_bus_state r_state;
    i2c_ram_pkg::t_bus_state n_state;
    i2c_ram_pkg::t_bus_state seg_next;
    i2c_ram_pkg::t_seg_kind  kind;
    i2c_ram_pkg::t_seg_kind  next_kind;

    logic [1:0] r_sub,    n_sub;
    logic [2:0] r_bit,    n_bit;
    logic [7:0] r_shift,  n_shift;
    logic [7:0] r_rdbuf,  n_rdbuf;
    logic       r_nack,   n_nack;
    logic       r_is_read, n_is_read;
    logic [7:0] r_dev,    n_dev;
    logic [7:0] r_reg,    n_reg;
    logic [7:0] r_data,   n_data;

    logic       idle;
    logic       req_ok;
    logic       last_sub;
    logic       bit_kind;
    logic [7:0] src_byte;

    assign kind      = i2c_ram_pkg::seg_kind(r_state);
    assign idle      = (r_state == i2c_ram_pkg::ST_IDLE);
    assign req_ok    = (i_req_type == i2c_ram_pkg::REQ_WRITE) ||
                       (i_req_type == i2c_ram_pkg::REQ_READ);
    assign last_sub  = (r_sub == i2c_ram_pkg::sub_last(kind));
    assign bit_kind  = (kind == i2c_ram_pkg::K_WB) || (kind == i2c_ram_pkg::K_RB);
    assign next_kind = i2c_ram_pkg::seg_kind(seg_next);

    // Segment order of both programs; they part after the register address.
    always_comb begin
        case (r_state)
            i2c_ram_pkg::ST_START:    seg_next = i2c_ram_pkg::ST_DEV;
            i2c_ram_pkg::ST_DEV:      seg_next = i2c_ram_pkg::ST_ACK_DEV;
            i2c_ram_pkg::ST_ACK_DEV:  seg_next = i2c_ram_pkg::ST_REG;
            i2c_ram_pkg::ST_REG:      seg_next = i2c_ram_pkg::ST_ACK_REG;
            i2c_ram_pkg::ST_ACK_REG:  seg_next = r_is_read ? i2c_ram_pkg::ST_RSTART
                                                           : i2c_ram_pkg::ST_DATA;
            i2c_ram_pkg::ST_DATA:     seg_next = i2c_ram_pkg::ST_ACK_DATA;
            i2c_ram_pkg::ST_ACK_DATA: seg_next = i2c_ram_pkg::ST_STOP;
            i2c_ram_pkg::ST_RSTART:   seg_next = i2c_ram_pkg::ST_DEVR;
            i2c_ram_pkg::ST_DEVR:     seg_next = i2c_ram_pkg::ST_ACK_DEVR;
            i2c_ram_pkg::ST_ACK_DEVR: seg_next = i2c_ram_pkg::ST_RDBYTE;
            i2c_ram_pkg::ST_RDBYTE:   seg_next = i2c_ram_pkg::ST_STOP;
            default:                  seg_next = i2c_ram_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (seg_next)
            i2c_ram_pkg::ST_DEV:  src_byte = r_dev;
            i2c_ram_pkg::ST_REG:  src_byte = r_reg;
            i2c_ram_pkg::ST_DATA: src_byte = r_data;
            i2c_ram_pkg::ST_DEVR: src_byte = r_dev + 8'd1;
            default:              src_byte = 8'd0;
        endcase
    end

    // Next state and datapath.
    always_comb begin
        n_state   = r_state;
        n_sub     = r_sub;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_rdbuf   = r_rdbuf;
        n_nack    = r_nack;
        n_is_read = r_is_read;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        if (i_step) begin
            if (idle) begin
                if (req_ok) begin
                    n_is_read = (i_req_type == i2c_ram_pkg::REQ_READ);
                    n_dev     = i_dev_addr;
                    n_reg     = i_reg_addr;
                    n_data    = i_wr_data;
                    n_nack    = 1'b0;
                    n_shift   = 8'd0;
                    n_state   = i2c_ram_pkg::ST_START;
                    n_sub     = 2'd0;
                    n_bit     = 3'd0;
                end
            end else if (i_phase_end) begin
                // SDA is sampled at the end of step 1 of an ack or read-bit slot, while SCL is high.
                if (kind == i2c_ram_pkg::K_ACK && r_sub == 2'd1) begin
                    n_nack = r_nack | i_sda_in;
                end
                if (kind == i2c_ram_pkg::K_RB && r_sub == 2'd1) begin
                    n_shift = {r_shift[6:0], i_sda_in};
                end
                if (!last_sub) begin
                    n_sub = r_sub + 2'd1;
                end else if (bit_kind && r_bit != 3'd7) begin
                    n_bit = r_bit + 3'd1;
                    n_sub = 2'd0;
                    if (kind == i2c_ram_pkg::K_WB) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                end else begin
                    if (kind == i2c_ram_pkg::K_RB) begin
                        n_rdbuf = r_shift;
                    end
                    n_state = seg_next;
                    n_sub   = 2'd0;
                    n_bit   = 3'd0;
                    if (next_kind == i2c_ram_pkg::K_WB) begin
                        n_shift = src_byte;
                    end else if (next_kind == i2c_ram_pkg::K_RB) begin
                        n_shift = 8'd0;
                    end
                end
            end
        end
    end

    // Line drive, status and timer control.
    always_comb begin
        o_result.scl = 1'b1;
        o_result.sda = 1'b1;
        case (kind)
            i2c_ram_pkg::K_START: begin
                o_result.sda = (r_sub != 2'd0) ? 1'b0 : 1'b1;
            end
            i2c_ram_pkg::K_WB: begin
                o_result.scl = (r_sub == 2'd1);
                o_result.sda = r_shift[7];
            end
            i2c_ram_pkg::K_ACK: begin
                o_result.scl = (r_sub == 2'd1) || (r_sub == 2'd2);
            end
            i2c_ram_pkg::K_RB: begin
                o_result.scl = (r_sub != 2'd2);
            end
            i2c_ram_pkg::K_STOP: begin
                o_result.scl = (r_sub != 2'd0);
                o_result.sda = (r_sub == 2'd2);
            end
            default: begin
                o_result.scl = 1'b1;
                o_result.sda = 1'b1;
            end
        endcase
        o_result.busy    = !idle || req_ok;
        o_result.done    = (r_state == i2c_ram_pkg::ST_STOP) && i_phase_end && last_sub;
        o_result.rd_data = n_rdbuf;
        o_result.nack    = n_nack;
        o_tmr_ctl.step   = i_step && !idle;
        o_tmr_ctl.clear  = i_step && idle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= i2c_ram_pkg::ST_IDLE;
            r_sub     <= 2'd0;
            r_bit     <= 3'd0;
            r_shift   <= 8'd0;
            r_rdbuf   <= 8'd0;
            r_nack    <= 1'b0;
            r_is_read <= 1'b0;
            r_dev     <= 8'd0;
            r_reg     <= 8'd0;
            r_data    <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_sub     <= n_sub;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_rdbuf   <= n_rdbuf;
            r_nack    <= n_nack;
            r_is_read <= n_is_read;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2c_ram_checker.sv
// ----------------------------------------------------------------------------
// I2C register access master port checker
// Watches the ports of the core for handshake and bus-status consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2c_ram_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire       o_scl_out,
    input wire       o_sda_out,
    input wire       o_busy_res,
    input wire       o_done_res,
    input wire [7:0] o_rd_data
);

    `ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_rd_data) && $stable(o_scl_out) && $stable(o_sda_out), "stalled output transaction changed")
    `ASSERT_IMP(a_done_lines, o_out_valid && o_done_res, o_busy_res && o_scl_out && o_sda_out, "done without busy or with a line held low")
    `ASSERT_IMP(a_idle_lines, o_out_valid && !o_busy_res, o_scl_out && o_sda_out && !o_done_res, "idle tick drives a line low or reports done")
    `ASSERT_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled while the output side can move")

endmodule

bind i2c_register_access_master_core i2c_ram_checker u_chk (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives bus ticks into the master and checks every per-tick line drive and
// status result against an in-bench model of the write and read sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_RSVD = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} t_sda_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = REQ_NONE;
    logic [7:0]  i_dev_addr = 8'h00;
    logic [7:0]  i_reg_addr = 8'h00;
    logic [7:0]  i_wr_data = 8'h00;
    logic        i_sda_in = 1'b1;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_scl_out;
    logic        o_sda_out;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rd_data;
    logic        o_nack_seen;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;

    // Model state of the master, at its reset values.
    logic [3:0]  bus_seg = 4'd0;
    logic [1:0]  bus_sub = 2'd0;
    logic [3:0]  bits_sent = 4'd0;
    logic [7:0]  shreg = 8'h00;
    logic [16:0] tick_ctr = 17'd0;
    logic [24:0] held_req = 25'd0;
    logic [7:0]  rd_byte = 8'h00;
    logic        nack_sticky = 1'b0;
    logic [15:0] phase_cfg = 16'd1;

    i2c_ram_pkg::t_result bus_tick_q[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_gap_left = 0;
    int unsigned rx_hold_left = 0;
    logic        tx_gaps_on = 1'b1;
    logic        rx_gaps_on = 1'b1;
    t_sda_mode   sda_mode = SDA_RAND;

    i2c_register_access_master_core #(.DIVIDER_WIDTH(16)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_dev_addr  (i_dev_addr),
        .i_reg_addr  (i_reg_addr),
        .i_wr_data   (i_wr_data),
        .i_sda_in    (i_sda_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scl_out   (o_scl_out),
        .o_sda_out   (o_sda_out),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rd_data   (o_rd_data),
        .o_nack_seen (o_nack_seen),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the bus sequencer
    // ------------------------------------------------------------------
    function automatic i2c_ram_pkg::t_seg_kind segment_kind(input logic rd,
                                                            input logic [3:0] seg);
        i2c_ram_pkg::t_seg_kind k;
        case (seg)
            4'd1:    k = i2c_ram_pkg::K_START;
            4'd2:    k = i2c_ram_pkg::K_WB;
            4'd3:    k = i2c_ram_pkg::K_ACK;
            4'd4:    k = i2c_ram_pkg::K_WB;
            4'd5:    k = i2c_ram_pkg::K_ACK;
            4'd6:    k = rd ? i2c_ram_pkg::K_START : i2c_ram_pkg::K_WB;
            4'd7:    k = rd ? i2c_ram_pkg::K_WB : i2c_ram_pkg::K_ACK;
            4'd8:    k = rd ? i2c_ram_pkg::K_ACK : i2c_ram_pkg::K_STOP;
            4'd9:    k = i2c_ram_pkg::K_RB;
            default: k = i2c_ram_pkg::K_STOP;
        endcase
        return k;
    endfunction

    function automatic int steps_in(input i2c_ram_pkg::t_seg_kind k);
        case (k)
            i2c_ram_pkg::K_START: return 2;
            i2c_ram_pkg::K_ACK:   return 4;
            default:              return 3;
        endcase
    endfunction

    // Byte shifted out by the write-byte segment at the given position.
    function automatic logic [7:0] byte_for(input logic [3:0] seg);
        case (seg)
            4'd2:    return held_req[23:16];
            4'd4:    return held_req[15:8];
            4'd6:    return held_req[7:0];
            4'd7:    return held_req[23:16] + 8'd1;
            default: return 8'h00;
        endcase
    endfunction

    function automatic void bus_to_idle();
        bus_seg = 4'd0;
        bus_sub = 2'd0;
        bits_sent = 4'd0;
        tick_ctr = 17'd0;
    endfunction

    function automatic i2c_ram_pkg::t_result next_bus_tick(input logic [1:0] req,
                                                           input logic [7:0] dev,
                                                           input logic [7:0] reg_a,
                                                           input logic [7:0] wd,
                                                           input logic sda_s);
        i2c_ram_pkg::t_result   r;
        i2c_ram_pkg::t_seg_kind kind;
        i2c_ram_pkg::t_seg_kind nxt;
        logic      rd;
        logic [3:0] plen;
        logic [1:0] sub;
        logic [15:0] period;
        logic      msb;

        r.scl = 1'b1;
        r.sda = 1'b1;
        r.busy = 1'b0;
        r.done = 1'b0;
        rd = held_req[24];
        plen = rd ? 4'd10 : 4'd8;
        sub = bus_sub;

        if (bus_seg == 4'd0 || bus_seg > plen) begin
            if (bus_seg != 4'd0)
                bus_to_idle();
            if (req == i2c_ram_pkg::REQ_WRITE || req == i2c_ram_pkg::REQ_READ) begin
                held_req = {req == i2c_ram_pkg::REQ_READ, dev, reg_a, wd};
                nack_sticky = 1'b0;
                shreg = 8'h00;
                bus_seg = 4'd1;
                bus_sub = 2'd0;
                bits_sent = 4'd0;
                tick_ctr = 17'd0;
                r.busy = 1'b1;
            end
        end else begin
            kind = segment_kind(rd, bus_seg);
            msb = shreg[7];
            period = (phase_cfg == 16'd0) ? 16'd1 : phase_cfg;
            if (sub >= steps_in(kind))
                sub = 2'd0;

            case (kind)
                i2c_ram_pkg::K_START: begin
                    r.scl = 1'b1;
                    r.sda = (sub == 2'd0);
                end
                i2c_ram_pkg::K_WB: begin
                    r.scl = (sub == 2'd1);
                    r.sda = msb;
                end
                i2c_ram_pkg::K_ACK: begin
                    r.scl = (sub == 2'd1 || sub == 2'd2);
                    r.sda = 1'b1;
                end
                i2c_ram_pkg::K_RB: begin
                    r.scl = (sub != 2'd2);
                    r.sda = 1'b1;
                end
                default: begin
                    r.scl = (sub != 2'd0);
                    r.sda = (sub == 2'd2);
                end
            endcase
            r.busy = 1'b1;

            tick_ctr = tick_ctr + 17'd1;
            if (tick_ctr >= {1'b0, period}) begin
                tick_ctr = 17'd0;
                // SDA is sampled on the last tick of the second step of a slot.
                if (kind == i2c_ram_pkg::K_ACK && sub == 2'd1)
                    nack_sticky = nack_sticky | sda_s;
                if (kind == i2c_ram_pkg::K_RB && sub == 2'd1)
                    shreg = {shreg[6:0], sda_s};

                if (sub + 1 < steps_in(kind)) begin
                    bus_sub = sub + 2'd1;
                end else if ((kind == i2c_ram_pkg::K_WB || kind == i2c_ram_pkg::K_RB) &&
                             bits_sent < 4'd7) begin
                    bits_sent = bits_sent + 4'd1;
                    if (kind == i2c_ram_pkg::K_WB)
                        shreg = {shreg[6:0], 1'b0};
                    bus_sub = 2'd0;
                end else begin
                    if (kind == i2c_ram_pkg::K_RB)
                        rd_byte = shreg;
                    if (bus_seg >= plen) begin
                        bus_to_idle();
                        r.done = 1'b1;
                    end else begin
                        nxt = segment_kind(rd, bus_seg + 4'd1);
                        bits_sent = 4'd0;
                        if (nxt == i2c_ram_pkg::K_WB)
                            shreg = byte_for(bus_seg + 4'd1);
                        else if (nxt == i2c_ram_pkg::K_RB)
                            shreg = 8'h00;
                        bus_seg = bus_seg + 4'd1;
                        bus_sub = 2'd0;
                    end
                end
            end
        end

        r.rd_data = rd_byte;
        r.nack = nack_sticky;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result check first, then the prediction for a tick taken at this edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        i2c_ram_pkg::t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (bus_tick_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: result with no tick outstanding", $realtime);
                end else begin
                    want = bus_tick_q.pop_front();
                    if (o_scl_out !== want.scl || o_sda_out !== want.sda ||
                        o_busy_res !== want.busy || o_done_res !== want.done ||
                        o_rd_data !== want.rd_data || o_nack_seen !== want.nack) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: mismatch scl/sda/busy/done/rd/nack", $realtime);
                            $display("  expected %b %b %b %b %02h %b actual %b %b %b %b %02h %b",
                                     want.scl, want.sda, want.busy, want.done,
                                     want.rd_data, want.nack, o_scl_out, o_sda_out,
                                     o_busy_res, o_done_res, o_rd_data, o_nack_seen);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                phase_cfg = i_cfg_data;
            if (i_in_valid && !o_in_stall)
                bus_tick_q.push_back(next_bus_tick(i_req_type, i_dev_addr, i_reg_addr,
                                                   i_wr_data, i_sda_in));
        end
    end

    // Output side pacing: a random hold after each result, plus a long hold on request.
    always @(posedge i_clk) begin : rx_pacing
        int unsigned gap;
        gap = rx_gap_left;
        if (o_out_valid && !i_out_stall)
            gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
        else if (gap != 0)
            gap = gap - 1;
        rx_gap_left <= gap;
        i_out_stall <= (gap != 0) || (rx_hold_left != 0);
    end

    always @(posedge i_clk) begin
        if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic sda_level();
        case (sda_mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_tick(input logic [1:0] req, input logic [7:0] dev,
                             input logic [7:0] reg_a, input logic [7:0] wd, input logic sda_s);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_dev_addr <= dev;
        i_reg_addr <= reg_a;
        i_wr_data <= wd;
        i_sda_in <= sda_s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_idle(input int n);
        repeat (n)
            send_tick(REQ_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), sda_level());
    endtask

    // Stop offering ticks and let every outstanding result come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (bus_tick_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_phase_ticks(input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_ticks();
        sda_mode = SDA_RAND;
        send_idle(4);
        repeat (3) send_tick(REQ_RSVD, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_tick(REQ_RSVD, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_write_transfers();
        sda_mode = SDA_LOW;
        send_tick(i2c_ram_pkg::REQ_WRITE, 8'hFE, 8'h00, 8'hFF, 1'b0);
        send_idle(95);
        sda_mode = SDA_HIGH;
        send_tick(i2c_ram_pkg::REQ_WRITE, 8'h01, 8'hFF, 8'h00, 1'b1);
        send_idle(95);
    endtask

    task automatic test_read_transfers();
        // A device address of 0xFF wraps to 0x00 in the read phase.
        sda_mode = SDA_HIGH;
        send_tick(i2c_ram_pkg::REQ_READ, 8'hFF, 8'h80, 8'h5A, 1'b1);
        send_idle(120);
        sda_mode = SDA_LOW;
        send_tick(i2c_ram_pkg::REQ_READ, 8'h00, 8'h7F, 8'hA5, 1'b0);
        send_idle(120);
        sda_mode = SDA_RAND;
        send_tick(i2c_ram_pkg::REQ_READ, 8'hA0, 8'h3C, 8'hC3, 1'b0);
        send_idle(120);
    endtask

    task automatic test_requests_while_busy();
        sda_mode = SDA_RAND;
        send_tick(i2c_ram_pkg::REQ_WRITE, 8'h42, 8'h24, 8'h99, 1'b0);
        repeat (60)
            send_tick(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sda_level());
        send_idle(130);
    endtask

    task automatic test_period_extremes();
        wait_drained();
        write_phase_ticks(16'd0);
        sda_mode = SDA_RAND;
        send_tick(i2c_ram_pkg::REQ_WRITE, 8'h5A, 8'hC3, 8'h3C, 1'b0);
        send_idle(95);
        // The longest period holds the first bus step; the transfer then
        // finishes at one tick per step.
        wait_drained();
        write_phase_ticks(16'hFFFF);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        send_tick(i2c_ram_pkg::REQ_READ, 8'h3C, 8'h11, 8'h22, 1'b0);
        send_idle(200);
        wait_drained();
        write_phase_ticks(16'd1);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_idle(130);
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold_left <= 200;
        sda_mode = SDA_RAND;
        send_tick(i2c_ram_pkg::REQ_READ, 8'h90, 8'h09, 8'h66, 1'b0);
        send_idle(120);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [15:0] periods[6];
        int unsigned pick;
        periods = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd0, 16'd1};
        periods[5] = 16'($urandom_range(1, 4));
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            write_phase_ticks(periods[ph]);
            pick = $urandom_range(0, 3);
            tx_gaps_on = pick[0];
            rx_gaps_on = pick[1];
            for (int i = 0; i < 80; i++) begin
                if (i % 60 == 0)
                    sda_mode = t_sda_mode'($urandom_range(0, 2));
                pick = $urandom_range(0, 9);
                send_tick(pick < 3 ? i2c_ram_pkg::REQ_WRITE :
                          pick < 6 ? i2c_ram_pkg::REQ_READ :
                          pick == 6 ? REQ_RSVD : REQ_NONE,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), sda_level());
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_write_transfers();
        test_read_transfers();
        test_requests_while_busy();
        test_period_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
